/* rtl/qgi_pkg.sv */
// ----------------------------------------------------------------------------
// qgi_pkg
// Shared types, codes and helpers for the quadratic grid interpolator.
// ----------------------------------------------------------------------------
package qgi_pkg;

  localparam int MAX_NODES_DEF   = 64;
  localparam int NUM_COLUMNS_DEF = 64;
  localparam int CNT_W           = 7;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_INTERP = 2'd1,
    CMD_EXTRAP = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_COINC = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [5:0]         node_index;
    logic [5:0]         column;
    logic signed [31:0] node_position;
    logic signed [31:0] node_value;
    logic signed [31:0] query_position;
  } item_t;

  localparam logic signed [49:0] Q_MAX = 50'sd2147483647;
  localparam logic signed [49:0] Q_MIN = -50'sd2147483648;

  function automatic logic ovf50(input logic signed [49:0] v);
    return (v > Q_MAX) || (v < Q_MIN);
  endfunction

  function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > Q_MAX) r = 32'sh7fffffff;
    else if (v < Q_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* rtl/quadratic_grid_interpolator_core.sv */
// ----------------------------------------------------------------------------
// quadratic_grid_interpolator_core
// Three-point Lagrange interpolation over a loaded grid, signed Q16.16.
// ----------------------------------------------------------------------------
// Items enter through a two-deep queue and are executed one at a time. An
// interpolate query runs a linear node search (one registered position-table
// read per candidate node), then the midpoint step, node fetch and
// coincidence check, then six ratio divisions on the shared
// two-bit-per-cycle divider, then dispatch, the multiplies, the final sum
// and the output register. Extrapolate queries skip the search and the
// midpoint step; queries with fewer than three nodes answer without search
// or division. A result waits in the output register until popped while
// the input queue keeps taking items until it is full.
module quadratic_grid_interpolator_core #(
  parameter int MAX_NODES   = qgi_pkg::MAX_NODES_DEF,
  parameter int NUM_COLUMNS = qgi_pkg::NUM_COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_node_count,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_cmd,
  input  logic [5:0]         in_node_index,
  input  logic [5:0]         in_column,
  input  logic signed [31:0] in_node_position,
  input  logic signed [31:0] in_node_value,
  input  logic signed [31:0] in_query_position,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status
);
  import qgi_pkg::*;

  logic [CNT_W-1:0] node_count_r;
  item_t            q_item;
  logic             q_valid;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
    end else if (cfg_we) begin
      node_count_r <= cfg_node_count;
    end
  end

  qgi_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_cmd(in_cmd), .in_node_index(in_node_index), .in_column(in_column),
    .in_node_position(in_node_position), .in_node_value(in_node_value),
    .in_query_position(in_query_position),
    .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
  );

  qgi_back #(.MAX_NODES(MAX_NODES), .NUM_COLUMNS(NUM_COLUMNS)) u_back (
    .clk(clk), .rst_n(rst_n), .node_count(node_count_r),
    .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
    .empty(empty), .pop(pop),
    .result_value(out_result_value), .status(out_status)
  );

endmodule

/* rtl/qgi_ram.sv */
// ----------------------------------------------------------------------------
// qgi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qgi_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/qgi_div.sv */
// ----------------------------------------------------------------------------
// qgi_div
// Signed divider, truncating toward zero, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module qgi_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [48:0] num,
  input  logic signed [32:0] den,
  output logic               done,
  output logic signed [49:0] quot
);

  localparam int DIV_STEPS = 25;

  logic        busy_r;
  logic        done_r;
  logic        neg_r;
  logic [4:0]  cnt_r;
  logic [49:0] dvd_r;
  logic [32:0] den_r;
  logic [32:0] rem_r;
  logic [49:0] quo_r;

  logic [49:0] dvd_nxt;
  logic [32:0] rem_nxt;
  logic [49:0] quo_nxt;
  logic [49:0] num_ext;
  logic [33:0] den_ext;

  assign num_ext = {num[48], num};
  assign den_ext = {den[32], den};

  always_comb begin
    logic [33:0] sh;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int s = 0; s < 2; s++) begin
      sh      = {rem_nxt, dvd_nxt[49]};
      dvd_nxt = {dvd_nxt[48:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = 33'(sh - {1'b0, den_r});
        quo_nxt = {quo_nxt[48:0], 1'b1};
      end else begin
        rem_nxt = sh[32:0];
        quo_nxt = {quo_nxt[48:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= num_ext[49] ? 50'(-num_ext) : num_ext;
        den_r  <= den_ext[33] ? 33'(-den_ext) : den_ext[32:0];
        rem_r  <= '0;
        quo_r  <= '0;
        neg_r  <= num[48] ^ den[32];
      end else if (busy_r) begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

/* rtl/qgi_front.sv */
// ----------------------------------------------------------------------------
// qgi_front
// Input side: takes items, drops unused commands, queues two deep.
// ----------------------------------------------------------------------------
module qgi_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_cmd,
  input  logic [5:0]         in_node_index,
  input  logic [5:0]         in_column,
  input  logic signed [31:0] in_node_position,
  input  logic signed [31:0] in_node_value,
  input  logic signed [31:0] in_query_position,
  output qgi_pkg::item_t     q_item,
  output logic               q_valid,
  input  logic               q_pop
);
  import qgi_pkg::*;

  item_t      entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       accept;
  logic       keep;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign accept  = push && !full;
  assign keep    = (in_cmd == CMD_LOAD) || (in_cmd == CMD_INTERP) || (in_cmd == CMD_EXTRAP);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = entry_r[rd_ptr_r];
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (accept && keep) begin
        entry_r[wr_ptr_r] <= '{cmd: cmd_t'(in_cmd), node_index: in_node_index,
                               column: in_column, node_position: in_node_position,
                               node_value: in_node_value,
                               query_position: in_query_position};
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(accept && keep) - 2'(do_pop);
    end
  end

endmodule

/* rtl/qgi_back.sv */
// ----------------------------------------------------------------------------
// qgi_back
// Execution side: grid tables, node search and the Lagrange evaluation.
// ----------------------------------------------------------------------------
module qgi_back #(
  parameter int MAX_NODES   = qgi_pkg::MAX_NODES_DEF,
  parameter int NUM_COLUMNS = qgi_pkg::NUM_COLUMNS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [6:0]            node_count,
  input  qgi_pkg::item_t        q_item,
  input  logic                  q_valid,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [31:0]    result_value,
  output logic [1:0]            status
);
  import qgi_pkg::*;

  localparam int PAW    = $clog2(MAX_NODES);
  localparam int VDEPTH = MAX_NODES * NUM_COLUMNS;
  localparam int VAW    = $clog2(VDEPTH);
  localparam int NW     = $clog2(MAX_NODES + 1);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_LOAD  = 18'h00002,
    S_SRD   = 18'h00004,
    S_SCMP  = 18'h00008,
    S_MRD0  = 18'h00010,
    S_MRD1  = 18'h00020,
    S_MCMP  = 18'h00040,
    S_NRD   = 18'h00080,
    S_NLD   = 18'h00100,
    S_CHK   = 18'h00200,
    S_DIV   = 18'h00400,
    S_DWAIT = 18'h00800,
    S_WMUL  = 18'h01000,
    S_WSAT  = 18'h02000,
    S_VMUL  = 18'h04000,
    S_VACC  = 18'h08000,
    S_FIN   = 18'h10000,
    S_OUT   = 18'h20000
  } state_t;

  state_t             state_r;
  item_t              item_r;
  logic [NW-1:0]      n_r;
  logic [NW-1:0]      i_r;
  logic [NW-1:0]      mid_r;
  logic [1:0]         k_r;
  logic [2:0]         j_r;
  logic signed [31:0] pa_r, pb_r, pc_r, pm_r;
  logic signed [31:0] v_r [3];
  logic signed [31:0] w_r [3];
  logic signed [31:0] r1_r, r2_r;
  logic signed [63:0] prod_r;
  logic signed [49:0] hi_r;
  logic [17:0]        lo_r;
  logic               sat_r;
  logic signed [31:0] res_r;
  status_t            status_r;

  // table ports
  logic             pos_we, val_we;
  logic [PAW-1:0]   pos_waddr, pos_raddr;
  logic [VAW-1:0]   val_waddr, val_raddr;
  logic [31:0]      pos_rdata, val_rdata;
  logic signed [31:0] pos_rd;

  logic [NW-1:0]    n_in;
  logic [NW-1:0]    nm2;
  logic [NW-1:0]    node_k;
  logic             ld_ok;
  logic             col_ok;
  logic signed [31:0] x;

  // divider
  logic               div_start, div_done;
  logic signed [32:0] dnum, dden;
  logic signed [49:0] div_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_sh;
  logic signed [49:0] total;

  assign x       = item_r.query_position;
  assign pos_rd  = $signed(pos_rdata);
  assign nm2     = n_r - NW'(2);
  assign node_k  = NW'(mid_r + NW'(k_r) - NW'(1));
  assign n_in    = (int'(node_count) > MAX_NODES) ? NW'(MAX_NODES) : NW'(node_count);
  assign ld_ok   = (int'(item_r.node_index) < MAX_NODES) && (int'(item_r.column) < NUM_COLUMNS);
  assign col_ok  = int'(item_r.column) < NUM_COLUMNS;

  assign pos_we    = (state_r == S_LOAD) && ld_ok;
  assign val_we    = pos_we;
  assign pos_waddr = PAW'(item_r.node_index);
  assign val_waddr = VAW'(int'(item_r.node_index) * NUM_COLUMNS + int'(item_r.column));
  assign val_raddr = VAW'(int'(node_k) * NUM_COLUMNS + int'(item_r.column));

  always_comb begin
    unique case (state_r)
      S_SRD:   pos_raddr = PAW'(i_r);
      S_MRD0:  pos_raddr = PAW'(mid_r);
      S_MRD1:  pos_raddr = PAW'(mid_r + NW'(1));
      default: pos_raddr = PAW'(node_k);
    endcase
  end

  qgi_ram #(.W(32), .DEPTH(MAX_NODES)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(item_r.node_position),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  qgi_ram #(.W(32), .DEPTH(VDEPTH)) u_val (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(item_r.node_value),
    .raddr(val_raddr), .rdata(val_rdata)
  );

  // ratio operands: (x-b)/(a-b), (x-c)/(a-c), (x-a)/(b-a), (x-c)/(b-c),
  // (x-a)/(c-a), (x-b)/(c-b)
  always_comb begin
    case (j_r)
      3'd0:    begin dnum = 33'(x) - 33'(pb_r); dden = 33'(pa_r) - 33'(pb_r); end
      3'd1:    begin dnum = 33'(x) - 33'(pc_r); dden = 33'(pa_r) - 33'(pc_r); end
      3'd2:    begin dnum = 33'(x) - 33'(pa_r); dden = 33'(pb_r) - 33'(pa_r); end
      3'd3:    begin dnum = 33'(x) - 33'(pc_r); dden = 33'(pb_r) - 33'(pc_r); end
      3'd4:    begin dnum = 33'(x) - 33'(pa_r); dden = 33'(pc_r) - 33'(pa_r); end
      default: begin dnum = 33'(x) - 33'(pb_r); dden = 33'(pc_r) - 33'(pb_r); end
    endcase
  end

  assign div_start = (state_r == S_DIV);

  qgi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num({dnum, 16'h0000}), .den(dden), .done(div_done), .quot(div_q)
  );

  assign mul_a   = (state_r == S_WMUL) ? r1_r : w_r[k_r];
  assign mul_b   = (state_r == S_WMUL) ? r2_r : v_r[k_r];
  assign prod_sh = prod_r >>> 16;
  assign total   = hi_r + {48'h0, lo_r[17:16]};

  assign q_pop        = (state_r == S_IDLE) && q_valid;
  assign empty        = (state_r != S_OUT);
  assign result_value = res_r;
  assign status       = status_r;

  always_ff @(posedge clk) begin
    logic [NW-1:0] mc;
    logic signed [34:0] lhs, rhs;
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r <= q_item;
            n_r    <= n_in;
            sat_r  <= 1'b0;
            if (q_item.cmd == CMD_LOAD) begin
              state_r <= S_LOAD;
            end else if (int'(n_in) < 3) begin
              res_r    <= '0;
              status_r <= ST_FEW;
              state_r  <= S_OUT;
            end else if (q_item.cmd == CMD_EXTRAP) begin
              mid_r   <= n_in - NW'(2);
              k_r     <= '0;
              state_r <= S_NRD;
            end else begin
              i_r     <= NW'(1);
              mid_r   <= '0;
              state_r <= S_SRD;
            end
          end
        end
        S_LOAD: state_r <= S_IDLE;
        S_SRD:  state_r <= S_SCMP;
        S_SCMP: begin
          mc = (x > pos_rd) ? i_r : mid_r;
          if (i_r == n_r - NW'(1)) begin
            mid_r   <= (mc > nm2) ? nm2 : mc;
            state_r <= S_MRD0;
          end else begin
            mid_r   <= mc;
            i_r     <= i_r + NW'(1);
            state_r <= S_SRD;
          end
        end
        S_MRD0: state_r <= S_MRD1;
        S_MRD1: begin
          pm_r    <= pos_rd;
          state_r <= S_MCMP;
        end
        S_MCMP: begin
          // step right when the point lies past the midpoint
          lhs = (35'(x) - 35'(pm_r)) <<< 1;
          rhs = 35'(pos_rd) - 35'(pm_r);
          mc  = mid_r + NW'(lhs > rhs);
          if (mc == '0) mc = NW'(1);
          if (mc > nm2) mc = nm2;
          mid_r   <= mc;
          k_r     <= '0;
          state_r <= S_NRD;
        end
        S_NRD: state_r <= S_NLD;
        S_NLD: begin
          case (k_r)
            2'd0:    pa_r <= pos_rd;
            2'd1:    pb_r <= pos_rd;
            default: pc_r <= pos_rd;
          endcase
          v_r[k_r] <= col_ok ? $signed(val_rdata) : 32'sd0;
          if (k_r == 2'd2) begin
            state_r <= S_CHK;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_NRD;
          end
        end
        S_CHK: begin
          hi_r <= '0;
          lo_r <= '0;
          j_r  <= '0;
          if (pa_r == pb_r || pa_r == pc_r || pb_r == pc_r) begin
            res_r    <= '0;
            status_r <= ST_COINC;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            if (ovf50(div_q)) sat_r <= 1'b1;
            if (!j_r[0]) begin
              r1_r    <= sat50(div_q);
              j_r     <= j_r + 3'd1;
              state_r <= S_DIV;
            end else begin
              r2_r    <= sat50(div_q);
              state_r <= S_WMUL;
            end
          end
        end
        S_WMUL: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_WSAT;
        end
        S_WSAT: begin
          w_r[j_r[2:1]] <= sat50(prod_sh[49:0]);
          if (ovf50(prod_sh[49:0])) sat_r <= 1'b1;
          if (j_r == 3'd5) begin
            k_r     <= '0;
            state_r <= S_VMUL;
          end else begin
            j_r     <= j_r + 3'd1;
            state_r <= S_DIV;
          end
        end
        S_VMUL: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_VACC;
        end
        S_VACC: begin
          hi_r <= hi_r + prod_sh[49:0];
          lo_r <= lo_r + {2'b00, prod_r[15:0]};
          if (k_r == 2'd2) begin
            state_r <= S_FIN;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_VMUL;
          end
        end
        S_FIN: begin
          res_r    <= sat50(total);
          status_r <= (sat_r || ovf50(total)) ? ST_SAT : ST_OK;
          state_r  <= S_OUT;
        end
        S_OUT: begin
          if (pop) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
